FILE: hdl/asg_pkg.sv
// ----------------------------------------------------------------------------
// asg_pkg
// Shared constants and types for the pure-pursuit steering geometry pipeline.
// ----------------------------------------------------------------------------
package asg_pkg;

	localparam int CORDIC_N = 30;
	localparam int QUO_W    = 31;

	typedef logic [31:0] bangle_t;

	localparam logic [30:0]        SAT31    = 31'h7FFF_FFFF;
	localparam bangle_t            QUARTER  = 32'h4000_0000;
	localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
	localparam logic [28:0]        RAD_MUL  = 29'd421657428;

	localparam bangle_t ATN [0:CORDIC_N-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	localparam logic [2:0] REG_WHEELBASE    = 3'd0;
	localparam logic [2:0] REG_STEER_RATIO  = 3'd1;
	localparam logic [2:0] REG_MAX_STEERING = 3'd2;
	localparam logic [2:0] REG_TARGET_SPEED = 3'd3;
	localparam logic [2:0] REG_GOAL_TOL     = 3'd4;

endpackage

FILE: hdl/asg_isqrt.sv
// ----------------------------------------------------------------------------
// asg_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module asg_isqrt #(
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [63:0]   in_val,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [31:0]   out_root,
	output logic [TW-1:0] out_tag
);

	localparam int L = 32;

	logic [63:0]   rem_s  [0:L];
	logic [63:0]   root_s [0:L];
	logic [TW-1:0] tag_s  [0:L];
	logic          vld_s  [0:L];

	always_comb begin
		rem_s[0]  = in_val;
		root_s[0] = '0;
		tag_s[0]  = in_tag;
		vld_s[0]  = in_valid;
	end

	for (genvar g = 0; g < L; g++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
		logic [64:0] trial;
		logic        ge;

		always_comb begin
			trial = {1'b0, root_s[g]} + {1'b0, BIT};
			ge    = {1'b0, rem_s[g]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
				if (ge) begin
					rem_s[g+1]  <= rem_s[g] - trial[63:0];
					root_s[g+1] <= (root_s[g] >> 1) + BIT;
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[L];
	assign out_root  = root_s[L][31:0];
	assign out_tag   = tag_s[L];

endmodule

FILE: hdl/asg_vec.sv
// ----------------------------------------------------------------------------
// asg_vec
// Pipelined CORDIC vectoring unit: normalize, fold into the right half plane,
// then thirty iterations giving atan2(y, x) as a 32-bit binary angle.
// ----------------------------------------------------------------------------
module asg_vec #(
	parameter int IW = 33,
	parameter int TW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [IW-1:0]  in_x,
	input  logic signed [IW-1:0]  in_y,
	input  logic [TW-1:0]         in_tag,
	output logic                  out_valid,
	output asg_pkg::bangle_t      out_ang,
	output logic [TW-1:0]         out_tag
);

	localparam int W  = 60;
	localparam int MW = 56;
	localparam int NN = 6;
	localparam int L  = 1 + NN + 1 + asg_pkg::CORDIC_N;

	logic signed [W-1:0]  x_s   [1:L];
	logic signed [W-1:0]  y_s   [1:L];
	asg_pkg::bangle_t     z_s   [1:L];
	logic [MW-1:0]        m_s   [1:L];
	logic                 zf_s  [1:L];
	logic [TW-1:0]        tag_s [0:L];
	logic                 vld_s [0:L];

	always_comb begin
		tag_s[0] = in_tag;
		vld_s[0] = in_valid;
	end

	for (genvar g = 0; g < L; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
			end
		end

		if (g == 0) begin : g_prep
			logic signed [W-1:0] xe, ye;
			logic [W-1:0]        xa, ya;

			always_comb begin
				xe = W'(in_x);
				ye = W'(in_y);
				xa = xe[W-1] ? W'(-xe) : W'(xe);
				ya = ye[W-1] ? W'(-ye) : W'(ye);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[1]  <= xe;
					y_s[1]  <= ye;
					z_s[1]  <= '0;
					m_s[1]  <= (xa > ya) ? xa[MW-1:0] : ya[MW-1:0];
					zf_s[1] <= (xa == '0) && (ya == '0);
				end
			end
		end else if (g <= NN) begin : g_norm
			localparam int SH = 32 >> (g - 1);
			localparam logic [MW-1:0] LIM = MW'(1) << (MW - SH);

			always_ff @(posedge clk) begin
				if (en) begin
					zf_s[g+1] <= zf_s[g];
					z_s[g+1]  <= z_s[g];
					if (m_s[g] < LIM) begin
						x_s[g+1] <= x_s[g] <<< SH;
						y_s[g+1] <= y_s[g] <<< SH;
						m_s[g+1] <= m_s[g] << SH;
					end else begin
						x_s[g+1] <= x_s[g];
						y_s[g+1] <= y_s[g];
						m_s[g+1] <= m_s[g];
					end
				end
			end
		end else if (g == NN + 1) begin : g_quad
			always_ff @(posedge clk) begin
				if (en) begin
					zf_s[g+1] <= zf_s[g];
					m_s[g+1]  <= m_s[g];
					if (x_s[g] < 0) begin
						if (y_s[g] >= 0) begin
							x_s[g+1] <= y_s[g];
							y_s[g+1] <= -x_s[g];
							z_s[g+1] <= asg_pkg::QUARTER;
						end else begin
							x_s[g+1] <= -y_s[g];
							y_s[g+1] <= x_s[g];
							z_s[g+1] <= -asg_pkg::QUARTER;
						end
					end else begin
						x_s[g+1] <= x_s[g];
						y_s[g+1] <= y_s[g];
						z_s[g+1] <= '0;
					end
				end
			end
		end else begin : g_iter
			localparam int I = g - NN - 2;

			always_ff @(posedge clk) begin
				if (en) begin
					zf_s[g+1] <= zf_s[g];
					m_s[g+1]  <= m_s[g];
					if (y_s[g] > 0) begin
						x_s[g+1] <= x_s[g] + (y_s[g] >>> I);
						y_s[g+1] <= y_s[g] - (x_s[g] >>> I);
						z_s[g+1] <= z_s[g] + asg_pkg::ATN[I];
					end else begin
						x_s[g+1] <= x_s[g] - (y_s[g] >>> I);
						y_s[g+1] <= y_s[g] + (x_s[g] >>> I);
						z_s[g+1] <= z_s[g] - asg_pkg::ATN[I];
					end
				end
			end
		end
	end

	assign out_valid = vld_s[L];
	assign out_ang   = zf_s[L] ? '0 : z_s[L];
	assign out_tag   = tag_s[L];

endmodule

FILE: hdl/asg_rot.sv
// ----------------------------------------------------------------------------
// asg_rot
// Pipelined CORDIC rotation unit giving the Q30 sine of a binary angle.
// ----------------------------------------------------------------------------
module asg_rot #(
	parameter int TW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  asg_pkg::bangle_t    in_ang,
	input  logic [TW-1:0]       in_tag,
	output logic                out_valid,
	output logic signed [35:0]  out_sin,
	output logic [TW-1:0]       out_tag
);

	localparam int L = 1 + asg_pkg::CORDIC_N;
	localparam logic signed [33:0] Q = 34'sd1073741824;

	logic signed [35:0] x_s   [1:L];
	logic signed [35:0] y_s   [1:L];
	logic signed [33:0] z_s   [1:L];
	logic [TW-1:0]      tag_s [0:L];
	logic               vld_s [0:L];

	always_comb begin
		tag_s[0] = in_tag;
		vld_s[0] = in_valid;
	end

	for (genvar g = 0; g < L; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
			end
		end

		if (g == 0) begin : g_prep
			logic signed [33:0] za;

			always_comb begin
				za = 34'($signed(in_ang));
			end

			always_ff @(posedge clk) begin
				if (en) begin
					priority if (za > Q) begin
						x_s[1] <= '0;
						y_s[1] <= asg_pkg::CORDIC_K;
						z_s[1] <= za - Q;
					end else if (za < -Q) begin
						x_s[1] <= '0;
						y_s[1] <= -asg_pkg::CORDIC_K;
						z_s[1] <= za + Q;
					end else begin
						x_s[1] <= asg_pkg::CORDIC_K;
						y_s[1] <= '0;
						z_s[1] <= za;
					end
				end
			end
		end else begin : g_iter
			localparam int I = g - 1;
			localparam logic signed [33:0] A = $signed({2'b00, asg_pkg::ATN[I]});

			always_ff @(posedge clk) begin
				if (en) begin
					if (z_s[g] >= 0) begin
						x_s[g+1] <= x_s[g] - (y_s[g] >>> I);
						y_s[g+1] <= y_s[g] + (x_s[g] >>> I);
						z_s[g+1] <= z_s[g] - A;
					end else begin
						x_s[g+1] <= x_s[g] + (y_s[g] >>> I);
						y_s[g+1] <= y_s[g] - (x_s[g] >>> I);
						z_s[g+1] <= z_s[g] + A;
					end
				end
			end
		end
	end

	assign out_valid = vld_s[L];
	assign out_sin   = y_s[L];
	assign out_tag   = tag_s[L];

endmodule

FILE: hdl/asg_div.sv
// ----------------------------------------------------------------------------
// asg_div
// Pipelined restoring divider with a 31-bit quotient; overflow
// (including a zero divisor) is flagged up front.
// ----------------------------------------------------------------------------
module asg_div #(
	parameter int NW = 63,
	parameter int DW = 32,
	parameter int TW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [NW-1:0]            in_num,
	input  logic [DW-1:0]            in_den,
	input  logic [TW-1:0]            in_tag,
	output logic                     out_valid,
	output logic [asg_pkg::QUO_W-1:0] out_quo,
	output logic                     out_ovf,
	output logic [TW-1:0]            out_tag
);

	localparam int QW = asg_pkg::QUO_W;
	localparam int L  = QW + 1;

	logic [DW-1:0] r_s   [1:L];
	logic [DW-1:0] d_s   [1:L];
	logic [QW-1:0] lo_s  [1:L];
	logic [QW-1:0] q_s   [1:L];
	logic          ov_s  [1:L];
	logic [TW-1:0] tag_s [0:L];
	logic          vld_s [0:L];

	always_comb begin
		tag_s[0] = in_tag;
		vld_s[0] = in_valid;
	end

	for (genvar g = 0; g < L; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
			end
		end

		if (g == 0) begin : g_init
			logic [NW-1:0] hi;
			logic          ovf;

			always_comb begin
				hi  = in_num >> QW;
				ovf = hi >= NW'(in_den);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[1]  <= ovf ? '0 : DW'(hi);
					d_s[1]  <= in_den;
					lo_s[1] <= in_num[QW-1:0];
					q_s[1]  <= '0;
					ov_s[1] <= ovf;
				end
			end
		end else begin : g_step
			localparam int B = QW - g;
			logic [DW:0] r2;
			logic        ge;

			always_comb begin
				r2 = {r_s[g], lo_s[g][B]};
				ge = r2 >= {1'b0, d_s[g]};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[g+1]  <= ge ? DW'(r2 - {1'b0, d_s[g]}) : DW'(r2);
					d_s[g+1]  <= d_s[g];
					lo_s[g+1] <= lo_s[g];
					q_s[g+1]  <= q_s[g] | (QW'(ge) << B);
					ov_s[g+1] <= ov_s[g];
				end
			end
		end
	end

	assign out_valid = vld_s[L];
	assign out_quo   = q_s[L];
	assign out_ovf   = ov_s[L];
	assign out_tag   = tag_s[L];

endmodule

FILE: hdl/ackermann_steering_geometry.sv
// ----------------------------------------------------------------------------
// ackermann_steering_geometry
// Pure-pursuit steering geometry: bearing, steering command, arc length,
// travel time, arrival heading and feasibility/reached flags per pose.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   pos_x pos_y heading goal_x goal_y
//   output   out        out_valid / out_stall steer_cmd arc_distance
//                                             travel_time goal_heading
//                                             feasible reached
//   config   in/out     APB psel/penable      paddr pwdata prdata pready
//
// One transaction per cycle sustained while the output is not stalled. The
// pipeline is a chain of square root, two CORDIC vectoring passes, CORDIC
// rotation and two dividers plus glue stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module ackermann_steering_geometry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] steer_cmd,
	output logic [30:0]        arc_distance,
	output logic [30:0]        travel_time,
	output logic signed [15:0] goal_heading,
	output logic               feasible,
	output logic               reached,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [15:0]        h;
		logic               ovf;
	} sq_tag_t;

	typedef struct packed {
		logic [32:0] gdist;
		logic [15:0] h;
	} v1_tag_t;

	typedef struct packed {
		asg_pkg::bangle_t alpha;
		logic [32:0]      gdist;
		logic [15:0]      h;
	} rot_tag_t;

	typedef struct packed {
		asg_pkg::bangle_t alpha;
		logic [32:0]      gdist;
		logic [15:0]      h;
		logic [62:0]      arcnum;
		logic [31:0]      sm;
	} v2_tag_t;

	typedef struct packed {
		logic [31:0]      steer;
		logic             feas;
		logic             reach;
		asg_pkg::bangle_t alpha;
		logic [32:0]      gdist;
		logic [15:0]      h;
	} da_tag_t;

	typedef struct packed {
		logic [31:0] steer;
		logic        feas;
		logic        reach;
		logic [30:0] arc;
		logic [15:0] gh;
	} dt_tag_t;

	logic [23:0] wheelbase_q;
	logic [15:0] steering_ratio_q;
	logic [14:0] max_steering_q;
	logic [23:0] target_speed_q;
	logic [30:0] goal_tolerance_q;

	logic en;
	logic wr;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q      <= 24'd173670;
			steering_ratio_q <= 16'd4429;
			max_steering_q   <= 15'd6258;
			target_speed_q   <= 24'd65536;
			goal_tolerance_q <= 31'd32768;
		end else if (wr) begin
			unique case (paddr[4:2])
				asg_pkg::REG_WHEELBASE:    wheelbase_q      <= pwdata[23:0];
				asg_pkg::REG_STEER_RATIO:  steering_ratio_q <= pwdata[15:0];
				asg_pkg::REG_MAX_STEERING: max_steering_q   <= pwdata[14:0];
				asg_pkg::REG_TARGET_SPEED: target_speed_q   <= pwdata[23:0];
				asg_pkg::REG_GOAL_TOL:     goal_tolerance_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			asg_pkg::REG_WHEELBASE:    prdata = {8'd0, wheelbase_q};
			asg_pkg::REG_STEER_RATIO:  prdata = {16'd0, steering_ratio_q};
			asg_pkg::REG_MAX_STEERING: prdata = {17'd0, max_steering_q};
			asg_pkg::REG_TARGET_SPEED: prdata = {8'd0, target_speed_q};
			asg_pkg::REG_GOAL_TOL:     prdata = {1'b0, goal_tolerance_q};
			default:                   prdata = '0;
		endcase
	end

	// s1: differences
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic [15:0]        h_s1;

	// s2: squares
	logic               v_s2;
	logic [63:0]        a2_s2, b2_s2;
	logic signed [32:0] dx_s2, dy_s2;
	logic [15:0]        h_s2;
	logic [32:0]        ax, ay;

	// s3: sum of squares
	logic        v_s3;
	logic [64:0] sum;
	logic [63:0] rin_s3;
	sq_tag_t     sq_in_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		ax  = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		ay  = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		sum = {1'b0, a2_s2} + {1'b0, b2_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({goal_x[31], goal_x}) - $signed({pos_x[31], pos_x});
			dy_s1 <= $signed({goal_y[31], goal_y}) - $signed({pos_y[31], pos_y});
			h_s1  <= heading;
			a2_s2 <= ax[31:0] * ax[31:0];
			b2_s2 <= ay[31:0] * ay[31:0];
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			h_s2  <= h_s1;
			rin_s3       <= sum[64] ? {1'b0, sum[64:2]} : sum[63:0];
			sq_in_s3.dx  <= dx_s2;
			sq_in_s3.dy  <= dy_s2;
			sq_in_s3.h   <= h_s2;
			sq_in_s3.ovf <= sum[64];
		end
	end

	logic        sq_v;
	logic [31:0] sq_root;
	sq_tag_t     sq_out;

	asg_isqrt #(.TW($bits(sq_tag_t))) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_val    (rin_s3),
		.in_tag    (sq_in_s3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_tag   (sq_out)
	);

	// s4: straight distance
	logic               v_s4;
	logic signed [32:0] dx_s4, dy_s4;
	v1_tag_t            v1_in_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s4          <= sq_out.dx;
			dy_s4          <= sq_out.dy;
			v1_in_s4.gdist <= sq_out.ovf ? {sq_root, 1'b0} : {1'b0, sq_root};
			v1_in_s4.h     <= sq_out.h;
		end
	end

	logic             v1_v;
	asg_pkg::bangle_t v1_ang;
	v1_tag_t          v1_out;

	asg_vec #(.IW(33), .TW($bits(v1_tag_t))) u_vec_bearing (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_x      (dx_s4),
		.in_y      (dy_s4),
		.in_tag    (v1_in_s4),
		.out_valid (v1_v),
		.out_ang   (v1_ang),
		.out_tag   (v1_out)
	);

	// s5: relative bearing
	logic     v_s5;
	rot_tag_t rot_in_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_in_s5.alpha <= (v1_out.gdist != '0) ? v1_ang - {v1_out.h, 16'h0000} : '0;
			rot_in_s5.gdist <= v1_out.gdist;
			rot_in_s5.h     <= v1_out.h;
		end
	end

	logic               rot_v;
	logic signed [35:0] rot_sin;
	rot_tag_t           rot_out;

	asg_rot #(.TW($bits(rot_tag_t))) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_ang    (rot_in_s5.alpha),
		.in_tag    (rot_in_s5),
		.out_valid (rot_v),
		.out_sin   (rot_sin),
		.out_tag   (rot_out)
	);

	// s6: lateral numerator product, bearing in radians, sine magnitude
	logic               v_s6;
	logic signed [56:0] prod_s6;
	logic [60:0]        rad_a_s6;
	logic [31:0]        sm_s6;
	rot_tag_t           p_s6;
	logic signed [31:0] sn32;
	logic [31:0]        amag6;

	always_comb begin
		sn32  = (rot_out.gdist != '0) ? rot_sin[31:0] : '0;
		amag6 = rot_out.alpha[31] ? 32'(-rot_out.alpha) : rot_out.alpha;
	end

	// s7: scale numerator, arc dividend
	logic               v_s7;
	logic signed [43:0] num_s7;
	logic [48:0]        distx_s7;
	v2_tag_t            v2_in_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= rot_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6  <= $signed({1'b0, wheelbase_q}) * sn32;
			rad_a_s6 <= amag6 * asg_pkg::RAD_MUL;
			sm_s6    <= sn32[31] ? 32'(-sn32) : 32'(sn32);
			p_s6     <= rot_out;
			num_s7          <= 44'(prod_s6 >>> 13);
			distx_s7        <= {p_s6.gdist, 16'h0000};
			v2_in_s7.alpha  <= p_s6.alpha;
			v2_in_s7.gdist  <= p_s6.gdist;
			v2_in_s7.h      <= p_s6.h;
			v2_in_s7.arcnum <= p_s6.gdist[30:0] * rad_a_s6[59:28];
			v2_in_s7.sm     <= sm_s6;
		end
	end

	logic             v2_v;
	asg_pkg::bangle_t v2_ang;
	v2_tag_t          v2_out;

	asg_vec #(.IW(51), .TW($bits(v2_tag_t))) u_vec_steer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_x      ($signed({2'b00, distx_s7})),
		.in_y      ($signed({{7{num_s7[43]}}, num_s7})),
		.in_tag    (v2_in_s7),
		.out_valid (v2_v),
		.out_ang   (v2_ang),
		.out_tag   (v2_out)
	);

	// s8..s10: road-wheel angle to steering command
	logic             v_s8, v_s9, v_s10;
	asg_pkg::bangle_t delta;
	logic [31:0]      dmag;
	logic [60:0]      rad_d_s8;
	logic [31:0]      dmag_s8;
	logic             dneg_s8, dneg_s9;
	v2_tag_t          p_s8, p_s9, p_s10;
	logic [25:0]      u_s9;
	logic             feas_s9, reach_s9;
	logic [47:0]      uprod;
	da_tag_t          da_in_s10;

	always_comb begin
		delta = (v2_out.gdist != '0) ? v2_ang : '0;
		dmag  = delta[31] ? 32'(-delta) : delta;
		uprod = rad_d_s8[59:28] * steering_ratio_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s8  <= v2_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_d_s8 <= dmag * asg_pkg::RAD_MUL;
			dmag_s8  <= dmag;
			dneg_s8  <= delta[31];
			p_s8     <= v2_out;
			u_s9     <= uprod[47:22];
			dneg_s9  <= dneg_s8;
			feas_s9  <= dmag_s8 <= {1'b0, max_steering_q, 16'h0000};
			reach_s9 <= p_s8.gdist <= {2'b00, goal_tolerance_q};
			p_s9     <= p_s8;
			da_in_s10.steer <= dneg_s9 ? 32'(-{6'd0, u_s9}) : {6'd0, u_s9};
			da_in_s10.feas  <= feas_s9;
			da_in_s10.reach <= reach_s9;
			da_in_s10.alpha <= p_s9.alpha;
			da_in_s10.gdist <= p_s9.gdist;
			da_in_s10.h     <= p_s9.h;
			p_s10           <= p_s9;
		end
	end

	logic        da_v;
	logic [30:0] da_quo;
	logic        da_ovf;
	da_tag_t     da_out;

	asg_div #(.NW(63), .DW(32), .TW($bits(da_tag_t))) u_div_arc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.in_num    (p_s10.arcnum),
		.in_den    (p_s10.sm),
		.in_tag    (da_in_s10),
		.out_valid (da_v),
		.out_quo   (da_quo),
		.out_ovf   (da_ovf),
		.out_tag   (da_out)
	);

	// s11: arc selection and arrival heading
	logic        v_s11;
	dt_tag_t     dt_in_s11;
	logic [31:0] amag11;
	logic [30:0] arc;
	logic [31:0] gh32;

	always_comb begin
		amag11 = da_out.alpha[31] ? 32'(-da_out.alpha) : da_out.alpha;
		priority if (da_out.gdist[32:31] != 2'b00) begin
			arc = asg_pkg::SAT31;
		end else if (amag11 < 32'd65536) begin
			arc = da_out.gdist[30:0];
		end else if (da_ovf) begin
			arc = asg_pkg::SAT31;
		end else begin
			arc = da_quo;
		end
		gh32 = {da_out.h, 16'h0000} + {da_out.alpha[30:0], 1'b0} + 32'h0000_8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= da_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dt_in_s11.steer <= da_out.steer;
			dt_in_s11.feas  <= da_out.feas;
			dt_in_s11.reach <= da_out.reach;
			dt_in_s11.arc   <= arc;
			dt_in_s11.gh    <= gh32[31:16];
		end
	end

	logic        dt_v;
	logic [30:0] dt_quo;
	logic        dt_ovf;
	dt_tag_t     dt_out;

	asg_div #(.NW(47), .DW(24), .TW($bits(dt_tag_t))) u_div_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.in_num    ({dt_in_s11.arc, 16'h0000}),
		.in_den    (target_speed_q),
		.in_tag    (dt_in_s11),
		.out_valid (dt_v),
		.out_quo   (dt_quo),
		.out_ovf   (dt_ovf),
		.out_tag   (dt_out)
	);

	// s12: output register
	logic        v_s12;
	logic [31:0] steer_s12;
	logic [30:0] arc_s12, tim_s12;
	logic [15:0] gh_s12;
	logic        feas_s12, reach_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= dt_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steer_s12 <= dt_out.steer;
			arc_s12   <= dt_out.arc;
			tim_s12   <= dt_ovf ? asg_pkg::SAT31 : dt_quo;
			gh_s12    <= dt_out.gh;
			feas_s12  <= dt_out.feas;
			reach_s12 <= dt_out.reach;
		end
	end

	assign out_valid    = v_s12;
	assign steer_cmd    = steer_s12;
	assign arc_distance = arc_s12;
	assign travel_time  = tim_s12;
	assign goal_heading = gh_s12;
	assign feasible     = feas_s12;
	assign reached      = reach_s12;

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(steer_cmd) && $stable(v_s1))
		else $error("pipeline advanced under output stall");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction not captured");

	a_zero_bearing: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && rot_in_s5.gdist == '0 |-> rot_in_s5.alpha == '0)
		else $error("nonzero bearing for goal on vehicle");

endmodule
